/* rtl/core/bsa_pkg.sv */
`default_nettype none

package bsa_pkg;

  // lane count and field widths
  localparam int MAX_LANES     = 3;
  localparam int LANES_DEFAULT = 3;
  localparam int VAL_W         = 32;
  localparam int K_W           = 32;

  // second difference t and stencil sum d, exact
  localparam int T_W = VAL_W + 2;
  localparam int D_W = T_W + 2;

  // split of d into a signed high part and an unsigned 16-bit low part
  localparam int LO_W   = 16;
  localparam int HI_W   = D_W - LO_W;
  localparam int PHI_W  = K_W + 1 + HI_W;
  localparam int PLO_W  = K_W + LO_W;
  localparam int RND_W  = PLO_W + 1 - LO_W;
  localparam int SUM_W  = PHI_W + 1;
  localparam int RES_W  = SUM_W + 1;

  // stream packing
  localparam int IN_DATA_W  = 2 * MAX_LANES * VAL_W;
  localparam int OUT_DATA_W = MAX_LANES * VAL_W;

  localparam logic [K_W-1:0] RIGIDITY_RESET = K_W'(32'h0001_0000);

  // control that travels with one word between stages
  typedef struct packed {
    logic valid;
    logic last;
  } word_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bsa_window.sv */
`default_nettype none

module bsa_window
  import bsa_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [VAL_W-1:0] pos [LANES],
  input  wire logic signed [VAL_W-1:0] acc [LANES],
  input  wire logic                    final_point,
  output word_ctl_t                    dn_ctl,
  input  wire logic                    dn_ready,
  output logic signed [D_W-1:0]        dn_d [LANES],
  output logic signed [VAL_W-1:0]      dn_y [LANES]
);

  localparam int SLOTS        = 3;
  localparam int SLOT_CUR     = 0;
  localparam int SLOT_FLUSH   = 1;
  localparam int SLOT_LAST    = 2;
  localparam logic [1:0] SEEN_MAX = 2'd3;

  // window state of the current fiber
  logic signed [VAL_W-1:0] pos_old [LANES];
  logic signed [VAL_W-1:0] pos_new [LANES];
  logic signed [T_W-1:0]   t_new   [LANES];
  logic signed [T_W-1:0]   t_old   [LANES];
  logic signed [VAL_W-1:0] acc_old [LANES];
  logic signed [VAL_W-1:0] acc_new [LANES];
  logic [1:0]              seen;

  // job register: up to three results waiting to issue
  logic [SLOTS-1:0]        job_mask;
  logic signed [T_W-1:0]   job_tn [LANES];
  logic signed [T_W-1:0]   job_t2 [LANES];
  logic signed [T_W-1:0]   job_t3 [LANES];
  logic signed [VAL_W-1:0] job_y  [SLOTS][LANES];

  logic                    accept;
  logic                    issue;
  logic [SLOTS-1:0]        cur_sel;
  logic [SLOTS-1:0]        mask_next;
  logic signed [T_W-1:0]   t_in [LANES];

  // issue the lowest pending slot whenever the next stage has room
  assign cur_sel   = job_mask & (~job_mask + SLOTS'(1));
  assign issue     = (job_mask != '0) && (!dn_ctl.valid || dn_ready);
  assign in_ready  = (job_mask == '0) ||
                     (((job_mask & (job_mask - SLOTS'(1))) == '0) && issue);
  assign accept    = in_valid && in_ready;

  // new second difference, zero until three points are in
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (seen[1]) begin
        t_in[l] = T_W'(pos_old[l]) - (T_W'(pos_new[l]) <<< 1) + T_W'(pos[l]);
      end else begin
        t_in[l] = '0;
      end
    end
  end

  always_comb begin
    mask_next = '0;
    mask_next[SLOT_CUR]   = seen[1];
    mask_next[SLOT_FLUSH] = final_point && (seen != 2'd0);
    mask_next[SLOT_LAST]  = final_point;
  end

  // window update, cleared after the last point of a fiber
  always_ff @(posedge clk) begin
    if (rst || (accept && final_point)) begin
      seen <= '0;
      for (int l = 0; l < LANES; l++) begin
        pos_old[l] <= '0;
        pos_new[l] <= '0;
        t_new[l]   <= '0;
        t_old[l]   <= '0;
        acc_old[l] <= '0;
        acc_new[l] <= '0;
      end
    end else if (accept) begin
      seen <= (seen == SEEN_MAX) ? SEEN_MAX : seen + 2'd1;
      for (int l = 0; l < LANES; l++) begin
        pos_old[l] <= pos_new[l];
        pos_new[l] <= pos[l];
        t_old[l]   <= t_new[l];
        t_new[l]   <= t_in[l];
        acc_old[l] <= acc_new[l];
        acc_new[l] <= acc[l];
      end
    end
  end

  // job slots
  always_ff @(posedge clk) begin
    if (rst) begin
      job_mask <= '0;
    end else if (accept) begin
      job_mask <= mask_next;
    end else if (issue) begin
      job_mask <= job_mask & ~cur_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int l = 0; l < LANES; l++) begin
        job_tn[l]              <= t_in[l];
        job_t2[l]              <= t_new[l];
        job_t3[l]              <= t_old[l];
        job_y[SLOT_CUR][l]     <= acc_old[l];
        job_y[SLOT_FLUSH][l]   <= acc_new[l];
        job_y[SLOT_LAST][l]    <= acc[l];
      end
    end
  end

  // stencil sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_ctl.valid <= 1'b0;
    end else if (!dn_ctl.valid || dn_ready) begin
      dn_ctl.valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      dn_ctl.last <= cur_sel[SLOT_LAST];
      for (int l = 0; l < LANES; l++) begin
        if (cur_sel[SLOT_CUR]) begin
          dn_d[l] <= D_W'(job_tn[l]) - (D_W'(job_t2[l]) <<< 1) + D_W'(job_t3[l]);
          dn_y[l] <= job_y[SLOT_CUR][l];
        end else if (cur_sel[SLOT_FLUSH]) begin
          dn_d[l] <= D_W'(job_t2[l]) - (D_W'(job_tn[l]) <<< 1);
          dn_y[l] <= job_y[SLOT_FLUSH][l];
        end else begin
          dn_d[l] <= D_W'(job_tn[l]);
          dn_y[l] <= job_y[SLOT_LAST][l];
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsa_scale.sv */
`default_nettype none

module bsa_scale
  import bsa_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [K_W-1:0]          rigidity,
  input  wire word_ctl_t               up_ctl,
  output logic                         up_ready,
  input  wire logic signed [D_W-1:0]   up_d [LANES],
  input  wire logic signed [VAL_W-1:0] up_y [LANES],
  output word_ctl_t                    out_ctl,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_val [LANES]
);

  localparam logic [PLO_W:0]     HALF    = (PLO_W + 1)'(1) << (LO_W - 1);
  localparam logic [VAL_W-1:0]   POS_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0]   NEG_MAX = {1'b1, {(VAL_W - 1){1'b0}}};

  // saturate to the signed 32-bit range
  function automatic logic [VAL_W-1:0] sat_val(input logic signed [RES_W-1:0] v);
    logic [RES_W-VAL_W:0] top;
    top = v[RES_W-1:VAL_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[VAL_W-1:0];
    end else if (v[RES_W-1]) begin
      return NEG_MAX;
    end else begin
      return POS_MAX;
    end
  endfunction

  word_ctl_t               mul_ctl;
  word_ctl_t               sum_ctl;
  logic                    mul_ready;
  logic                    sum_ready;
  logic                    out_room;

  logic signed [PHI_W-1:0] p_hi  [LANES];
  logic [PLO_W-1:0]        p_lo  [LANES];
  logic signed [VAL_W-1:0] y_mul [LANES];
  logic signed [SUM_W-1:0] s_sum [LANES];
  logic signed [VAL_W-1:0] y_sum [LANES];

  assign out_room  = !out_ctl.valid || out_ready;
  assign sum_ready = !sum_ctl.valid || out_room;
  assign mul_ready = !mul_ctl.valid || sum_ready;
  assign up_ready  = mul_ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_ctl.valid <= 1'b0;
      sum_ctl.valid <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_ctl.valid <= up_ctl.valid;
      end
      if (sum_ready) begin
        sum_ctl.valid <= mul_ctl.valid;
      end
      if (out_room) begin
        out_ctl.valid <= sum_ctl.valid;
      end
    end
  end

  // partial products k*hi and k*lo
  always_ff @(posedge clk) begin
    if (mul_ready && up_ctl.valid) begin
      mul_ctl.last <= up_ctl.last;
      for (int l = 0; l < LANES; l++) begin
        p_hi[l]  <= $signed({1'b0, rigidity}) * $signed(up_d[l][D_W-1:LO_W]);
        p_lo[l]  <= PLO_W'(rigidity) * PLO_W'(up_d[l][LO_W-1:0]);
        y_mul[l] <= up_y[l];
      end
    end
  end

  // round the low product and add the high one
  always_ff @(posedge clk) begin
    logic [PLO_W:0]   lo_sum;
    logic [RND_W-1:0] rnd;
    if (sum_ready && mul_ctl.valid) begin
      sum_ctl.last <= mul_ctl.last;
      for (int l = 0; l < LANES; l++) begin
        lo_sum   = {1'b0, p_lo[l]} + HALF;
        rnd      = lo_sum[PLO_W:LO_W];
        s_sum[l] <= SUM_W'(p_hi[l]) + $signed({1'b0, rnd});
        y_sum[l] <= y_mul[l];
      end
    end
  end

  // subtract and saturate into the output register
  always_ff @(posedge clk) begin
    if (out_room && sum_ctl.valid) begin
      out_ctl.last <= sum_ctl.last;
      for (int l = 0; l < LANES; l++) begin
        out_val[l] <= sat_val(RES_W'(y_sum[l]) - RES_W'(s_sum[l]));
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bending_stencil_apply.sv */
// Bending stencil over a stream of fiber points.
// Input stream (s_axis): one point per word; tdata holds the position and the
// accumulator value per coordinate, tlast marks the last point of a fiber.
// Output stream (m_axis): one updated accumulator per point, in point order;
// tlast marks the result for the fiber's last point.
// Results lag two points behind: the word for point j-2 is formed when point
// j is accepted, and the last point flushes the pending one or two words.
// A result passes the job register, stencil sum, multiply, round and output
// register in that order before m_axis_tvalid rises for it.
// Throughput: one point per cycle while the output does not stall. A last point
// that releases two or three results holds s_axis_tready low while the job
// register issues them.
// rigidity scales the stencil sum as unsigned Q16.16. The user must write it
// via cfg_wr_en / cfg_wr_data only while the block is idle; nothing enforces it.
// Reset clears the point window, empties the pipeline and sets rigidity to
// 1.0. When m_axis_tready is low the stages fill up and s_axis_tready drops.
`default_nettype none

module bending_stencil_apply
  import bsa_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [K_W-1:0]        cfg_wr_data,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_a, pos_b, pos_c, acc_a, acc_b, acc_c
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // final_point
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_a, out_b, out_c
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // out_last
  output logic                       m_axis_tlast
);

  logic [K_W-1:0]          rigidity;
  logic signed [VAL_W-1:0] pos     [LANES];
  logic signed [VAL_W-1:0] acc     [LANES];
  word_ctl_t               s2_ctl;
  logic                    s2_ready;
  logic signed [D_W-1:0]   s2_d    [LANES];
  logic signed [VAL_W-1:0] s2_y    [LANES];
  word_ctl_t               out_ctl;
  logic signed [VAL_W-1:0] out_val [LANES];

  // coefficient register
  always_ff @(posedge clk) begin
    if (rst) begin
      rigidity <= RIGIDITY_RESET;
    end else if (cfg_wr_en) begin
      rigidity <= cfg_wr_data;
    end
  end

  // unpack the input word
  for (genvar l = 0; l < LANES; l++) begin : g_unpack
    assign pos[l] = s_axis_tdata[l * VAL_W +: VAL_W];
    assign acc[l] = s_axis_tdata[(MAX_LANES + l) * VAL_W +: VAL_W];
  end

  bsa_window #(
    .LANES(LANES)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pos        (pos),
    .acc        (acc),
    .final_point(s_axis_tlast),
    .dn_ctl     (s2_ctl),
    .dn_ready   (s2_ready),
    .dn_d       (s2_d),
    .dn_y       (s2_y)
  );

  bsa_scale #(
    .LANES(LANES)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .rigidity (rigidity),
    .up_ctl   (s2_ctl),
    .up_ready (s2_ready),
    .up_d     (s2_d),
    .up_y     (s2_y),
    .out_ctl  (out_ctl),
    .out_ready(m_axis_tready),
    .out_val  (out_val)
  );

  // pack the output word, unused coordinates read as zero
  assign m_axis_tvalid = out_ctl.valid;
  assign m_axis_tlast  = out_ctl.last;

  for (genvar i = 0; i < MAX_LANES; i++) begin : g_pack
    if (i < LANES) begin : g_used
      assign m_axis_tdata[i * VAL_W +: VAL_W] = out_val[i];
    end else begin : g_zero
      assign m_axis_tdata[i * VAL_W +: VAL_W] = '0;
    end
  end

`ifndef NO_ASSERTIONS
  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s2_ctl.valid)
    else $error("pipeline not empty after reset");

  // with the receiver ready, a fiber-end word goes through mul, sum and out
  a_last_latency: assert property (@(posedge clk) disable iff (rst)
    (s2_ctl.valid && s2_ready && s2_ctl.last) ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid && m_axis_tlast)
    else $error("fiber-end word lost or delayed in scale pipeline");

  // while the stencil stage holds a word and the scaler stalls, it is kept
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid && !s2_ready |=> s2_ctl.valid && $stable(s2_ctl.last))
    else $error("stencil word dropped during stall");
`endif

endmodule

`default_nettype wire

/* tb/sv/bending_stencil_checker.sv */
`timescale 1ns / 100ps

module bending_stencil_checker
  import bsa_pkg::*;
#(
  parameter int LANES = LANES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [K_W-1:0]        cfg_wr_data,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // pos_a, pos_b, pos_c, acc_a, acc_b, acc_c
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // final_point
  input  wire logic                  s_axis_tlast,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_a, out_b, out_c
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  // out_last
  input  wire logic                  m_axis_tlast,
  output int                         mismatches,
  output int                         pending,
  output int                         points_in,
  output int                         words_out
);

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // one expected output word
  typedef struct packed {
    logic                  last;
    logic [OUT_DATA_W-1:0] vals;
  } update_word_t;

  update_word_t   due_updates[$];
  logic [K_W-1:0] k_coef;

  // per-lane point window of the current fiber
  longint pos_old [MAX_LANES];
  longint pos_new [MAX_LANES];
  longint t_new   [MAX_LANES];
  longint t_old   [MAX_LANES];
  longint acc_old [MAX_LANES];
  longint acc_new [MAX_LANES];
  int     seen;

  // accumulator and stencil sum picked for the word being formed
  longint y_sel [MAX_LANES];
  longint d_sel [MAX_LANES];

  // k * d with k in q16.16, rounded to an integer, ties toward plus infinity
  function automatic longint scale_by_k(longint d, logic [K_W-1:0] k);
    longint kk;
    longint lo;
    longint hi;
    kk = longint'({32'd0, k});
    lo = d & 64'sh0000_0000_0000_FFFF;
    hi = d >>> 16;
    return kk * hi + ((kk * lo + 64'sh8000) >>> 16);
  endfunction

  function automatic logic [VAL_W-1:0] clamp_val(longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[VAL_W-1:0];
  endfunction

  function automatic string lane_name(int l);
    case (l)
      0: return "out_a";
      1: return "out_b";
      default: return "out_c";
    endcase
  endfunction

  task automatic push_update(input logic last);
    update_word_t w;
    w = '0;
    for (int l = 0; l < LANES; l++) begin
      w.vals[l*VAL_W +: VAL_W] = clamp_val(y_sel[l] - scale_by_k(d_sel[l], k_coef));
    end
    w.last = last;
    due_updates.push_back(w);
  endtask

  task automatic clear_fiber();
    for (int l = 0; l < MAX_LANES; l++) begin
      pos_old[l] = 0;
      pos_new[l] = 0;
      t_new[l]   = 0;
      t_old[l]   = 0;
      acc_old[l] = 0;
      acc_new[l] = 0;
    end
    seen = 0;
  endtask

  // shift one point into the window and queue the words it releases
  task automatic take_point(input logic [IN_DATA_W-1:0] data, input logic fin);
    int     prior;
    longint x;
    longint tn;
    prior = seen;
    for (int l = 0; l < LANES; l++) begin
      x  = longint'($signed(data[l*VAL_W +: VAL_W]));
      tn = 0;
      if (prior >= 2) begin
        tn       = pos_old[l] - 2 * pos_new[l] + x;
        y_sel[l] = acc_old[l];
        d_sel[l] = tn - 2 * t_new[l] + t_old[l];
      end
      t_old[l]   = t_new[l];
      t_new[l]   = tn;
      pos_old[l] = pos_new[l];
      pos_new[l] = x;
      acc_old[l] = acc_new[l];
      acc_new[l] = longint'($signed(data[(MAX_LANES + l)*VAL_W +: VAL_W]));
    end
    if (prior >= 2) push_update(1'b0);
    seen = (prior < 3) ? prior + 1 : 3;

    // last point flushes the one or two pending words
    if (fin) begin
      if (prior >= 1) begin
        for (int l = 0; l < LANES; l++) begin
          y_sel[l] = acc_old[l];
          d_sel[l] = -2 * t_new[l] + t_old[l];
        end
        push_update(1'b0);
      end
      for (int l = 0; l < LANES; l++) begin
        y_sel[l] = acc_new[l];
        d_sel[l] = t_new[l];
      end
      push_update(1'b1);
      clear_fiber();
    end
  endtask

  task automatic check_update();
    update_word_t     w;
    logic [VAL_W-1:0] got;
    logic [VAL_W-1:0] want;
    if (due_updates.size() == 0) begin
      $error("result word 0x%h with no point waiting for it", m_axis_tdata);
      mismatches++;
      return;
    end
    w = due_updates.pop_front();
    for (int l = 0; l < MAX_LANES; l++) begin
      got  = m_axis_tdata[l*VAL_W +: VAL_W];
      want = w.vals[l*VAL_W +: VAL_W];
      if (got !== want) begin
        $error("%s: expected 0x%08h, got 0x%08h", lane_name(l), want, got);
        mismatches++;
      end
    end
    if (m_axis_tlast !== w.last) begin
      $error("out_last: expected %0b, got %0b", w.last, m_axis_tlast);
      mismatches++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      k_coef = RIGIDITY_RESET;
      clear_fiber();
      due_updates.delete();
    end else begin
      if (cfg_wr_en) k_coef = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        take_point(s_axis_tdata, s_axis_tlast);
        points_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_update();
        words_out++;
      end
    end
    pending = due_updates.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import bsa_pkg::*;

  localparam int               CYCLE_LIMIT  = 100000;
  localparam int               HOLD_CYCLES  = 80;
  localparam int               DRAIN_CYCLES = 10;
  localparam int               NEAR_SPAN    = 32'h0004_0000;
  localparam int               PHASE_POINTS = 30;
  localparam int               PHASES       = 5;
  localparam logic [VAL_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_ONES     = 32'hFFFF_FFFF;
  localparam logic [K_W-1:0]   K_HALF       = 32'h0000_8000;
  localparam logic [K_W-1:0]   K_FULL       = 32'hFFFF_FFFF;

  typedef enum int {STYLE_WIDE, STYLE_NEAR, STYLE_EDGE, STYLE_MIXED, STYLE_SMOOTH} style_t;
  typedef enum int {RX_OPEN, RX_PATTERN, RX_HOLD} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [K_W-1:0]        cfg_wr_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int       mismatches;
  int       pending;
  int       points_in;
  int       words_out;
  int       cycle_count = 0;
  int       burst_left  = 0;
  int       fibers_sent = 0;
  int       cfg_writes  = 0;
  int       holdoffs    = 0;
  bit       tx_steady   = 1'b0;
  rx_mode_t rx_mode     = RX_PATTERN;

  bending_stencil_apply u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bending_stencil_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .points_in     (points_in),
    .words_out     (words_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // output side: open, stall pattern, or one long hold-off
  initial begin
    int run;
    m_axis_tready = 1'b0;
    forever begin
      case (rx_mode)
        RX_OPEN: begin
          @(negedge clk);
          m_axis_tready <= 1'b1;
        end
        RX_PATTERN: begin
          run = $urandom_range(1, 10);
          repeat (run) begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
          end
          if ($urandom_range(0, 2) == 0) begin
            run = $urandom_range(1, 5);
            repeat (run) begin
              @(negedge clk);
              m_axis_tready <= 1'b0;
            end
          end
        end
        default: begin
          repeat (HOLD_CYCLES) begin
            @(negedge clk);
            m_axis_tready <= 1'b0;
          end
          holdoffs++;
          rx_mode = RX_PATTERN;
        end
      endcase
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_point(
    logic [VAL_W-1:0] pa, logic [VAL_W-1:0] pb, logic [VAL_W-1:0] pc,
    logic [VAL_W-1:0] aa, logic [VAL_W-1:0] ab, logic [VAL_W-1:0] ac);
    return {ac, ab, aa, pc, pb, pa};
  endfunction

  function automatic logic [VAL_W-1:0] field_value(style_t style);
    logic [VAL_W-1:0] v;
    case (style)
      STYLE_NEAR: begin
        v = $urandom_range(0, 2 * NEAR_SPAN);
        return v - NEAR_SPAN;
      end
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          3: return VAL_ONES;
          default: return 32'd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // offer one word, with bursts and gaps unless the sender is steady
  task automatic send_point(input logic [IN_DATA_W-1:0] data, input logic fin);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
        end
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_fiber(input int len, input style_t style);
    logic [VAL_W-1:0] pv [MAX_LANES];
    logic [VAL_W-1:0] av [MAX_LANES];
    logic [VAL_W-1:0] base [MAX_LANES];
    logic [VAL_W-1:0] step [MAX_LANES];
    for (int l = 0; l < MAX_LANES; l++) begin
      base[l] = $urandom();
      step[l] = field_value(STYLE_NEAR);
    end
    for (int j = 0; j < len; j++) begin
      for (int l = 0; l < MAX_LANES; l++) begin
        case (style)
          STYLE_SMOOTH: begin
            pv[l] = base[l] + j * step[l] + $urandom_range(0, 15);
            av[l] = field_value(STYLE_NEAR);
          end
          STYLE_MIXED: begin
            pv[l] = field_value(style_t'($urandom_range(0, 2)));
            av[l] = field_value(style_t'($urandom_range(0, 2)));
          end
          default: begin
            pv[l] = field_value(style);
            av[l] = field_value(style);
          end
        endcase
      end
      send_point(pack_point(pv[0], pv[1], pv[2], av[0], av[1], av[2]), j == len - 1);
    end
    fibers_sent++;
  endtask

  // drop valid and let every expected word out before touching the register
  task automatic settle_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_rigidity(input logic [K_W-1:0] k);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  // stimulus and verdict
  initial begin
    logic [K_W-1:0] k_pick;
    int             sent;
    int             len;
    int             pick;
    style_t         style;

    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-point fiber passes through
    send_point(pack_point(VAL_MAX, VAL_MIN, 32'h0001_8000, VAL_MAX, VAL_MIN, 32'hDEAD_BEEF), 1'b1);
    fibers_sent++;

    // two-point fiber passes through
    send_point(pack_point(32'd1, 32'd2, 32'd3, 32'h0000_1000, VAL_ONES, VAL_MIN), 1'b0);
    send_point(pack_point(VAL_ONES, VAL_MIN, VAL_MAX, VAL_MAX, 32'd7, 32'h1234_5678), 1'b1);
    fibers_sent++;

    // huge second differences at unit rigidity, saturating both ways
    send_point(pack_point(VAL_MAX, VAL_MIN, '0, VAL_MIN, VAL_MAX, '0), 1'b0);
    send_point(pack_point(VAL_MIN, VAL_MAX, VAL_ONES, VAL_MIN, VAL_MAX, VAL_ONES), 1'b0);
    send_point(pack_point(VAL_MAX, VAL_MIN, '0, VAL_MAX, VAL_MIN, 32'd1), 1'b1);
    fibers_sent++;
    send_fiber(4, STYLE_NEAR);

    // zero rigidity: every word equals its accumulator
    settle_idle();
    write_rigidity('0);
    send_fiber(3, STYLE_EDGE);

    // full-scale rigidity on extreme values
    settle_idle();
    write_rigidity(K_FULL);
    send_fiber(4, STYLE_EDGE);

    // half rigidity on unit differences: rounding ties both signs
    settle_idle();
    write_rigidity(K_HALF);
    send_point(pack_point('0, '0, '0, 32'd5, 32'd5, 32'd5), 1'b0);
    send_point(pack_point('0, '0, '0, 32'd5, 32'd5, 32'd5), 1'b0);
    send_point(pack_point(32'd1, VAL_ONES, 32'd3, 32'd5, 32'd5, 32'd5), 1'b1);
    fibers_sent++;

    // random phases, each at its own rigidity
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: k_pick = RIGIDITY_RESET;
        1: k_pick = $urandom_range(0, 4 * RIGIDITY_RESET);
        2: k_pick = $urandom_range(0, RIGIDITY_RESET);
        3: k_pick = $urandom();
        default: k_pick = K_FULL;
      endcase
      settle_idle();
      write_rigidity(k_pick);
      tx_steady  = (ph == 0);
      burst_left = 0;
      rx_mode    = (ph == 0) ? RX_OPEN : RX_PATTERN;

      // long output hold-off while a long fiber keeps coming
      if (ph == 2) begin
        rx_mode = RX_HOLD;
        send_fiber(24, STYLE_SMOOTH);
      end

      sent = 0;
      while (sent < PHASE_POINTS) begin
        pick = $urandom_range(0, 9);
        len  = (pick == 0) ? 1 : (pick == 1) ? 2 : $urandom_range(3, 10);
        pick = $urandom_range(0, 9);
        if (pick < 3)      style = STYLE_SMOOTH;
        else if (pick < 5) style = STYLE_NEAR;
        else if (pick < 7) style = STYLE_WIDE;
        else if (pick < 9) style = STYLE_MIXED;
        else               style = STYLE_EDGE;
        send_fiber(len, style);
        sent += len;
      end
    end

    // drain and decide
    settle_idle();
    $display("covered %0d points in %0d fibers, %0d result words checked",
             points_in, fibers_sent, words_out);
    $display("rigidity set %0d times incl. zero, half, unit and full scale; %0d long hold-off(s)",
             cfg_writes, holdoffs);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bsa_pkg.sv
rtl/core/bsa_window.sv
rtl/core/bsa_scale.sv
rtl/core/bending_stencil_apply.sv
tb/sv/bending_stencil_checker.sv
tb/sv/testbench.sv
